/* hw/rtl/bbf_pkg.sv */
// Shared types and constants of the blocked Bloom filter.
package bbf_pkg;

   localparam logic [63:0] MIX_MULT    = 64'h4cf2d24a9f24e7a5;
   localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;

   // Low factor word and the six bits above it that reach the probe position
   localparam logic [31:0] MIX_MULT_LO  = MIX_MULT[31:0];
   localparam logic [5:0]  MIX_MULT_LO6 = MIX_MULT[5:0];
   localparam logic [5:0]  MIX_MULT_HI6 = MIX_MULT[37:32];

   localparam int CFG_LOG2_W          = 4;
   localparam int BUCKET_LOG2_DEFAULT = 12;
   localparam int CSR_DATA_W          = 32;
   localparam int CSR_ADDR_W          = 3;

   localparam logic REG_BUCKET_LOG2 = 1'b0;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MIX,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } mix_ctrl_type;

endpackage

/* hw/rtl/bbf_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module bbf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/bbf_mask_unit.sv */
// Iterative probe-mask builder: one mixer round per cycle over a shared multiplier.
module bbf_mask_unit #(
   parameter int HASH_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bbf_pkg::mix_ctrl_type ctrl,
   input  logic [31:0]          seed,
   output logic [63:0]          mask,
   output logic                 round_last
);

   import bbf_pkg::*;

   localparam int CNT_W = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

   logic [63:0]      seed_ff, seed_in;
   logic [63:0]      mask_ff, mask_in;
   logic [CNT_W-1:0] round_ff, round_in;

   logic [31:0] w_lo;
   logic [5:0]  w_hi;
   logic [63:0] prod_lo;
   logic [11:0] cross_a;
   logic [11:0] cross_b;
   logic [5:0]  pos;

   // Only product bits 37..32 matter, so the 64-bit multiply splits into
   // one 32x32 product and two narrow cross terms.
   assign w_lo    = seed_ff[31:0] ^ seed_ff[63:32];
   assign w_hi    = seed_ff[37:32];
   assign prod_lo = w_lo * MIX_MULT_LO;
   assign cross_a = w_hi * MIX_MULT_LO6;
   assign cross_b = w_lo[5:0] * MIX_MULT_HI6;
   assign pos     = prod_lo[37:32] + cross_a[5:0] + cross_b[5:0];

   always_comb begin
      seed_in  = seed_ff;
      mask_in  = mask_ff;
      round_in = round_ff;
      if (ctrl.load) begin
         seed_in  = {32'b0, seed} + GOLDEN_STEP;
         mask_in  = '0;
         round_in = '0;
      end else if (ctrl.step) begin
         seed_in  = seed_ff + GOLDEN_STEP;
         mask_in  = mask_ff | (64'b1 << pos);
         round_in = round_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
      end else begin
         round_ff <= round_in;
      end
      seed_ff <= seed_in;
      mask_ff <= mask_in;
   end

   assign mask       = mask_ff;
   assign round_last = (round_ff == CNT_W'(HASH_COUNT - 1));

endmodule

/* hw/rtl/blocked_bloom_filter.sv */
// Blocked Bloom filter top level: bucket table, control sequencer and register port.
//
// Each accepted word passes through these steps in turn: accepting it and
// starting the bucket read, HASH_COUNT rounds in which the shared mixer builds the
// probe mask one round at a time, and a finishing step that writes the bucket back
// (insert) or loads the answer into the output register (query). A query
// waits in its finishing step while an earlier answer is still held by rsp_stall.
// After reset a clearing pass zeroes the table one bucket a cycle, and req_stall
// stays high meanwhile, while register writes are taken as usual. Inserts give
// no result word.
module blocked_bloom_filter #(
   parameter int BUCKETS_LOG2_MAX = 12,
   parameter int HASH_COUNT       = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [63:0]                       req_key_hash,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_maybe_present,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bbf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bbf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bbf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   import bbf_pkg::*;

   localparam int ADDR_W     = BUCKETS_LOG2_MAX;
   localparam int DEPTH      = 1 << BUCKETS_LOG2_MAX;
   localparam int LOG2_RESET = (BUCKETS_LOG2_MAX < BUCKET_LOG2_DEFAULT) ?
                               BUCKETS_LOG2_MAX : BUCKET_LOG2_DEFAULT;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clear_addr_ff, clear_addr_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  op_ff, op_in;
   logic [CFG_LOG2_W-1:0] cfg_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_present_ff, rsp_present_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [63:0]       ram_wdata;
   logic              ram_re;
   logic [63:0]       ram_rdata;

   mix_ctrl_type      mix_ctrl;
   logic [63:0]       mix_mask;
   logic              mix_last;
   logic [63:0]       probe_mask;
   logic              hit;

   logic [ADDR_W-1:0] index_sel;
   logic [ADDR_W-1:0] req_index;
   logic              csr_write;

   // A log2 above the table size sets every index bit, which saturates it
   always_comb begin
      for (int i = 0; i < ADDR_W; i++) begin
         index_sel[i] = (32'(cfg_ff) > i);
      end
   end

   assign req_index = req_key_hash[ADDR_W-1:0] & index_sel;

   assign probe_mask = (mix_mask == 64'b0) ? 64'b1 : mix_mask;
   assign hit        = ((ram_rdata & probe_mask) == probe_mask);

   bbf_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (req_index),
      .rdata (ram_rdata)
   );

   bbf_mask_unit #(
      .HASH_COUNT (HASH_COUNT)
   ) u_mask (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mix_ctrl),
      .seed       (req_key_hash[63:32]),
      .mask       (mix_mask),
      .round_last (mix_last)
   );

   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      addr_in        = addr_ff;
      op_in          = op_ff;
      rsp_present_in = rsp_present_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      req_stall      = 1'b1;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = ram_rdata | probe_mask;
      ram_re         = 1'b0;
      mix_ctrl       = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we        = 1'b1;
            ram_waddr     = clear_addr_ff;
            ram_wdata     = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ram_re        = 1'b1;
               mix_ctrl.load = 1'b1;
               addr_in       = req_index;
               op_in         = req_opcode;
               state_in      = ST_MIX;
            end
         end
         ST_MIX: begin
            mix_ctrl.step = 1'b1;
            if (mix_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (op_ff == OP_INSERT) begin
               ram_we   = 1'b1;
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               // hold until the earlier answer has been taken
               rsp_valid_in   = 1'b1;
               rsp_present_in = hit;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      op_ff          <= op_in;
      rsp_present_ff <= rsp_present_in;
   end

   // Register port: one register, decoded on the word address bit
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_BUCKET_LOG2);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_LOG2_W'(LOG2_RESET);
      end else if (csr_write) begin
         cfg_ff <= pwdata[CFG_LOG2_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_BUCKET_LOG2) ?
                   {{(CSR_DATA_W - CFG_LOG2_W){1'b0}}, cfg_ff} : '0;
   assign pready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = rsp_present_ff;

   a_accept_starts_mix: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_MIX)
      else $error("accepted word did not start the mixer");

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("bucket read issued during a table write");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH && $past(op_ff) == OP_QUERY)
      else $error("result word raised outside a query finish");

   a_query_answers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && op_ff == OP_QUERY && !(rsp_valid_ff && rsp_stall)
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("query finished without a result word");

endmodule

/* tb/bbf_answer_checker.sv */
// Bloom filter answer checker: predicts query answers from the watched words and compares them.
module bbf_answer_checker #(
   parameter int BUCKETS_LOG2_MAX = 12,
   parameter int HASH_COUNT       = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_opcode,
   input  logic [63:0]                    req_key_hash,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_maybe_present,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [bbf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bbf_pkg::CSR_DATA_W-1:0] pwdata,
   output int                             mismatches,
   output int                             answers_due
);

   import bbf_pkg::*;

   localparam int DEPTH = 1 << BUCKETS_LOG2_MAX;

   logic [63:0]           bucket_mem [DEPTH];
   logic [CFG_LOG2_W-1:0] log2_setting;
   logic                  answer_q [$];
   int                    errors;

   function automatic logic [63:0] probe_bits(input logic [63:0] hash);
      logic [63:0] seed;
      logic [63:0] v;
      logic [63:0] bits;
      seed = {32'd0, hash[63:32]};
      bits = '0;
      for (int r = 0; r < HASH_COUNT; r++) begin
         seed = seed + GOLDEN_STEP;
         v = seed ^ (seed >> 32);
         v = v * MIX_MULT;
         v = v ^ (v >> 32);
         bits[v[37:32]] = 1'b1;
      end
      return (bits == '0) ? 64'd1 : bits;
   endfunction

   // saturate an oversized setting so the index stays inside the table
   function automatic int unsigned bucket_index(input logic [63:0] hash);
      int unsigned lg;
      lg = (log2_setting > BUCKETS_LOG2_MAX) ? BUCKETS_LOG2_MAX : log2_setting;
      return hash[31:0] & ((32'd1 << lg) - 32'd1);
   endfunction

   task automatic note_mismatch(input string what, input logic want, input logic got);
      if (errors < 10)
         $display("mismatch at %0t: %s expected %b got %b", $time, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      logic [63:0] bits;
      int unsigned idx;
      logic        want;
      if (reset) begin
         foreach (bucket_mem[i]) bucket_mem[i] = '0;
         log2_setting = (BUCKET_LOG2_DEFAULT > BUCKETS_LOG2_MAX) ?
                        CFG_LOG2_W'(BUCKETS_LOG2_MAX) : CFG_LOG2_W'(BUCKET_LOG2_DEFAULT);
         answer_q.delete();
         errors = 0;
      end else begin
         // other register addresses are ignored
         if (psel && penable && pwrite && pready && paddr == {REG_BUCKET_LOG2, 2'b00})
            log2_setting = pwdata[CFG_LOG2_W-1:0];
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               note_mismatch("unexpected answer word, none", 1'bx, rsp_maybe_present);
            end else begin
               want = answer_q.pop_front();
               if (rsp_maybe_present !== want)
                  note_mismatch("maybe_present", want, rsp_maybe_present);
            end
         end
         if (req_valid && !req_stall) begin
            idx  = bucket_index(req_key_hash);
            bits = probe_bits(req_key_hash);
            if (req_opcode == OP_INSERT)
               bucket_mem[idx] = bucket_mem[idx] | bits;
            else
               answer_q.push_back((bucket_mem[idx] & bits) == bits);
         end
      end
      answers_due <= answer_q.size();
      mismatches  <= errors;
   end

endmodule

/* tb/tb_blocked_bloom_filter.sv */
// Testbench top of the blocked Bloom filter: stimulus, flow control, watchdog and verdict.
module tb_blocked_bloom_filter;
   import bbf_pkg::*;

   localparam int LOG2_MAX     = 12;
   localparam int PROBES       = 8;
   localparam int PHASE_ITEMS  = 250;
   localparam int DRAIN_CYCLES = PROBES + 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 20000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_LOG2   = {REG_BUCKET_LOG2, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = {~REG_BUCKET_LOG2, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_opcode;
   logic [63:0]           req_key_hash;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_maybe_present;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int          mismatches;
   int          answers_due;
   int          quiet;
   int          hold_left;
   logic        hold_go;
   logic        hold_done;
   logic        calm;
   logic [63:0] known_keys [$];
   int unsigned phase_log2 [$] = '{12, 0, 15, 1, 6, 13, 3, 12};

   blocked_bloom_filter #(
      .BUCKETS_LOG2_MAX(LOG2_MAX),
      .HASH_COUNT(PROBES)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_key_hash(req_key_hash),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_maybe_present(rsp_maybe_present),
      .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   bbf_answer_checker #(
      .BUCKETS_LOG2_MAX(LOG2_MAX),
      .HASH_COUNT(PROBES)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_key_hash(req_key_hash),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_maybe_present(rsp_maybe_present),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .mismatches(mismatches), .answers_due(answers_due)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // result side: random stalls, one long hold-off on request, none while calm
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 27);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_word(input logic op, input logic [63:0] hash);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key_hash <= hash;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every answer, then let a final insert finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_word();
      logic [63:0] h;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 40 || known_keys.size() == 0) begin
         h = {$urandom, $urandom};
         send_word(OP_INSERT, h);
         known_keys.push_back(h);
         if (known_keys.size() > 256) void'(known_keys.pop_front());
      end else if (pick < 75) begin
         send_word(OP_QUERY, known_keys[$urandom_range(known_keys.size() - 1)]);
      end else begin
         send_word(OP_QUERY, {$urandom, $urandom});
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_opcode   <= OP_INSERT;
      req_key_hash <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      hold_go      <= 1'b0;
      calm         <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_csr(ADDR_LOG2, BUCKET_LOG2_DEFAULT);
      // unmapped register: must leave the bucket count alone
      write_csr(ADDR_UNUSED, 32'hFFFF_FFF5);

      send_word(OP_QUERY,  64'h0000_0000_0000_0000);
      send_word(OP_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_INSERT, 64'h0000_0000_0000_0000);
      send_word(OP_QUERY,  64'h0000_0000_0000_0000);
      send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_QUERY,  64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_QUERY,  64'h0000_0000_FFFF_FFFF);
      send_word(OP_INSERT, 64'hFFFF_FFFF_0000_0000);
      send_word(OP_QUERY,  64'hFFFF_FFFF_0000_0000);
      send_word(OP_INSERT, 64'h8000_0000_0000_0001);
      send_word(OP_QUERY,  64'h0000_0000_0000_0001);
      send_word(OP_QUERY,  64'h0000_0001_0000_0000);
      // index bits above the bucket count fold onto the same bucket
      send_word(OP_INSERT, 64'h1234_5678_0000_1ABC);
      send_word(OP_QUERY,  64'h1234_5678_0000_0ABC);
      send_word(OP_QUERY,  64'hA5A5_A5A5_5A5A_5A5A);
      settle();
      write_csr(ADDR_LOG2, 32'd0);
      send_word(OP_QUERY,  64'h1234_5678_FFFF_FFFF);
      send_word(OP_QUERY,  64'h5A5A_5A5A_A5A5_A5A5);
      send_word(OP_INSERT, 64'h5A5A_5A5A_A5A5_A5A5);
      send_word(OP_QUERY,  64'h5A5A_5A5A_0000_0000);
      settle();
      // oversized setting saturates at the table size
      write_csr(ADDR_LOG2, 32'd15);
      send_word(OP_QUERY,  64'h1234_5678_0000_0ABC);
      send_word(OP_QUERY,  64'hFFFF_FFFF_0000_0FFF);

      foreach (phase_log2[p]) begin
         settle();
         write_csr(ADDR_LOG2, phase_log2[p]);
         calm <= (p == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 100) hold_go <= 1'b1;
            random_word();
         end
      end
      settle();

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
